/* rtl/core/cau_pkg.sv */
// Package for the complex arithmetic unit: widths, opcodes, item kinds and
// the structs passed between front end, queue and back end. No dependencies.
`default_nettype none
package cau_pkg;

  localparam int OPND_W    = 16;             // operand width (OPERAND_WIDTH)
  localparam int FRAC      = 8;              // operand fraction bits (FRAC_BITS)
  localparam int RES_W     = 34;             // result part width
  localparam int OP_W      = 3;
  localparam int PROD_W    = 2 * OPND_W;     // one product, also |num| and |b|^2
  localparam int SUM_W     = PROD_W + 1;     // sum of two products
  localparam int SHIFT     = 2 * FRAC;       // quotient / root scaling
  localparam int DIV_STEPS = RES_W - 1;      // quotient bits kept below the cap
  localparam int OVF_SH    = DIV_STEPS - SHIFT;
  localparam int ROOT_W    = (PROD_W + SHIFT) / 2;
  localparam int QDEPTH    = 4;
  localparam int QA_W      = $clog2(QDEPTH);

  // stream word layout
  localparam int IN_DATA_W  = 4 * OPND_W;
  localparam int OUT_DATA_W = ((2 * RES_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_MOD = 3'd4;

  typedef enum logic [2:0] {
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_MOD,
    K_NONE
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic                      dz;
    logic signed [PROD_W-1:0]  p_rr;   // a_re*b_re, or a_re^2 for modulus
    logic signed [PROD_W-1:0]  p_ii;   // a_im*b_im, or a_im^2 for modulus
    logic signed [PROD_W-1:0]  p_ri;   // a_re*b_im
    logic signed [PROD_W-1:0]  p_ir;   // a_im*b_re
    logic signed [PROD_W-1:0]  p_bre;  // b_re^2
    logic signed [PROD_W-1:0]  p_bim;  // b_im^2
    logic signed [RES_W-1:0]   as_re;  // add/sub result, already scaled
    logic signed [RES_W-1:0]   as_im;
  } qentry_t;

  typedef struct packed {
    logic [QA_W:0] cnt;
    logic          full;
    logic          empty;
  } qstat_t;

  typedef struct packed {
    kind_t                    kind;
    logic                     dz;
    logic signed [RES_W-1:0]  dir_re;
    logic signed [RES_W-1:0]  dir_im;
    logic                     neg_re;
    logic                     neg_im;
    logic                     ovf_re;
    logic                     ovf_im;
    logic [PROD_W-1:0]        nre;
    logic [PROD_W-1:0]        nim;
    logic [PROD_W-1:0]        den;
    logic [PROD_W-1:0]        rre;
    logic [PROD_W-1:0]        rim;
    logic [DIV_STEPS-1:0]     qre;
    logic [DIV_STEPS-1:0]     qim;
    logic [PROD_W-1:0]        sq;
    logic [ROOT_W+1:0]        srem;
    logic [ROOT_W-1:0]        root;
  } stage_t;

endpackage
`default_nettype wire

/* rtl/core/cau_front.sv */
// Front end: input register, opcode classification and the six operand
// products. Depends on cau_pkg.
`default_nettype none
module cau_front
  import cau_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,   // a_re, a_im, b_re, b_im
  input  wire logic [OP_W-1:0]      in_tuser,   // opcode
  output logic                      q_push,
  output qentry_t                   q_data,
  input  wire logic                 q_ready
);

  logic                      v_r;
  logic [OP_W-1:0]           op_r;
  logic signed [OPND_W-1:0]  ar_r, ai_r, br_r, bi_r;
  logic signed [OPND_W-1:0]  m0, m1;
  logic signed [OPND_W:0]    s_re, s_im;
  logic                      is_mod;

  assign in_tready = !v_r || q_ready;
  assign q_push    = v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_tready) begin
      v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r <= in_tuser;
      ar_r <= in_tdata[OPND_W-1:0];
      ai_r <= in_tdata[2*OPND_W-1:OPND_W];
      br_r <= in_tdata[3*OPND_W-1:2*OPND_W];
      bi_r <= in_tdata[4*OPND_W-1:3*OPND_W];
    end
  end

  always_comb begin
    is_mod = (op_r == OP_MOD);
    // modulus reuses the two main multipliers for the squares of a
    m0     = is_mod ? ar_r : br_r;
    m1     = is_mod ? ai_r : bi_r;
    s_re   = (op_r == OP_SUB) ? ((OPND_W+1)'(ar_r) - (OPND_W+1)'(br_r))
                              : ((OPND_W+1)'(ar_r) + (OPND_W+1)'(br_r));
    s_im   = (op_r == OP_SUB) ? ((OPND_W+1)'(ai_r) - (OPND_W+1)'(bi_r))
                              : ((OPND_W+1)'(ai_r) + (OPND_W+1)'(bi_r));

    q_data.dz    = 1'b0;
    q_data.p_rr  = ar_r * m0;
    q_data.p_ii  = ai_r * m1;
    q_data.p_ri  = ar_r * bi_r;
    q_data.p_ir  = ai_r * br_r;
    q_data.p_bre = br_r * br_r;
    q_data.p_bim = bi_r * bi_r;
    q_data.as_re = RES_W'(s_re) <<< FRAC;
    q_data.as_im = RES_W'(s_im) <<< FRAC;

    case (op_r)
      OP_ADD: q_data.kind = K_ADD;
      OP_SUB: q_data.kind = K_SUB;
      OP_MUL: q_data.kind = K_MUL;
      OP_DIV: begin
        if (br_r == '0 && bi_r == '0) begin
          q_data.kind = K_NONE;
          q_data.dz   = 1'b1;
        end else begin
          q_data.kind = K_DIV;
        end
      end
      OP_MOD:  q_data.kind = K_MOD;
      default: q_data.kind = K_NONE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/cau_queue.sv */
// Short register queue between front end and back end.
// Depends on cau_pkg.
`default_nettype none
module cau_queue
  import cau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire qentry_t  push_data,
  output logic          push_ready,
  output logic          pop_valid,
  output qentry_t       pop_data,
  input  wire logic     pop,
  output qstat_t        stat
);

  qentry_t          mem_r [QDEPTH];
  logic [QA_W-1:0]  wp_r, rp_r;
  logic [QA_W:0]    cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != (QA_W+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  assign stat.cnt   = cnt_r;
  assign stat.full  = !push_ready;
  assign stat.empty = !pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

/* rtl/core/cau_back.sv */
// Back end: product sums, pipelined restoring divider (two lanes) and
// square root, saturation and output register. Depends on cau_pkg.
`default_nettype none
module cau_back
  import cau_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire qentry_t               q_data,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,   // res_re, res_im
  output logic                       out_tuser    // div_zero
);

  localparam logic signed [RES_W-1:0] MAX_P = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] MIN_N = {1'b1, {(RES_W-1){1'b0}}};

  logic en;

  // sum stage
  logic                     v0_r;
  kind_t                    kind0_r;
  logic                     dz0_r;
  logic signed [SUM_W-1:0]  nr0_r, ni0_r;
  logic [PROD_W-1:0]        den0_r;
  logic signed [RES_W-1:0]  dre0_r, dim0_r;

  stage_t                   st [DIV_STEPS+1];
  stage_t                   st0_r;
  logic [DIV_STEPS:0]       vld_r;

  logic                     ov_r;
  logic signed [RES_W-1:0]  ore_r, oim_r;
  logic                     odz_r;

  assign en    = !ov_r || out_tready;
  assign q_pop = q_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      vld_r <= '0;
      ov_r  <= 1'b0;
    end else if (en) begin
      v0_r  <= q_valid;
      vld_r <= {vld_r[DIV_STEPS-1:0], v0_r};
      ov_r  <= vld_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind0_r <= q_data.kind;
      dz0_r   <= q_data.dz;
      nr0_r   <= SUM_W'(q_data.p_rr) + SUM_W'(q_data.p_ii);
      ni0_r   <= SUM_W'(q_data.p_ir) - SUM_W'(q_data.p_ri);
      den0_r  <= q_data.p_bre + q_data.p_bim;
      case (q_data.kind)
        K_ADD, K_SUB: begin
          dre0_r <= q_data.as_re;
          dim0_r <= q_data.as_im;
        end
        K_MUL: begin
          dre0_r <= RES_W'(SUM_W'(q_data.p_rr) - SUM_W'(q_data.p_ii));
          dim0_r <= RES_W'(SUM_W'(q_data.p_ri) + SUM_W'(q_data.p_ir));
        end
        default: begin
          dre0_r <= '0;
          dim0_r <= '0;
        end
      endcase
    end
  end

  // prep stage: magnitudes, signs, overflow against the cap, initial remainders
  logic [PROD_W-1:0] mre, mim;
  always_comb begin
    mre = nr0_r[SUM_W-1] ? PROD_W'(-nr0_r) : PROD_W'(nr0_r);
    mim = ni0_r[SUM_W-1] ? PROD_W'(-ni0_r) : PROD_W'(ni0_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st0_r.kind   <= kind0_r;
      st0_r.dz     <= dz0_r;
      st0_r.dir_re <= dre0_r;
      st0_r.dir_im <= dim0_r;
      st0_r.neg_re <= nr0_r[SUM_W-1];
      st0_r.neg_im <= ni0_r[SUM_W-1];
      // quotient reaches the cap exactly when |num| >> OVF_SH >= den
      st0_r.ovf_re <= (mre >> OVF_SH) >= den0_r;
      st0_r.ovf_im <= (mim >> OVF_SH) >= den0_r;
      st0_r.nre    <= mre;
      st0_r.nim    <= mim;
      st0_r.den    <= den0_r;
      st0_r.rre    <= mre >> OVF_SH;
      st0_r.rim    <= mim >> OVF_SH;
      st0_r.qre    <= '0;
      st0_r.qim    <= '0;
      st0_r.sq     <= PROD_W'(nr0_r);   // a_re^2 + a_im^2 for modulus
      st0_r.srem   <= '0;
      st0_r.root   <= '0;
    end
  end

  assign st[0] = st0_r;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int  J     = DIV_STEPS - 1 - k;
    localparam int  I     = ROOT_W - 1 - k;
    localparam bit  DO_SQ = (k < ROOT_W);

    logic              xb_re, xb_im;
    logic [1:0]        pair;
    logic [PROD_W:0]   t_re, t_im, d_ext;
    logic              ge_re, ge_im, ge_sq;
    logic [ROOT_W+3:0] sh, trial;
    stage_t            stg_nxt;
    stage_t            stg_r;

    if (J >= SHIFT) begin : g_xb
      assign xb_re = st[k].nre[J-SHIFT];
      assign xb_im = st[k].nim[J-SHIFT];
    end else begin : g_xz
      assign xb_re = 1'b0;
      assign xb_im = 1'b0;
    end

    if (k < ROOT_W && 2 * I >= SHIFT) begin : g_pr
      assign pair = st[k].sq[2*I-SHIFT +: 2];
    end else begin : g_pz
      assign pair = 2'b00;
    end

    always_comb begin
      stg_nxt = st[k];
      d_ext   = {1'b0, st[k].den};
      t_re    = {st[k].rre, xb_re};
      t_im    = {st[k].rim, xb_im};
      ge_re   = (t_re >= d_ext);
      ge_im   = (t_im >= d_ext);
      stg_nxt.rre = ge_re ? PROD_W'(t_re - d_ext) : t_re[PROD_W-1:0];
      stg_nxt.rim = ge_im ? PROD_W'(t_im - d_ext) : t_im[PROD_W-1:0];
      stg_nxt.qre = {st[k].qre[DIV_STEPS-2:0], ge_re};
      stg_nxt.qim = {st[k].qim[DIV_STEPS-2:0], ge_im};

      sh    = {st[k].srem, pair};
      trial = (ROOT_W+4)'({st[k].root, 2'b01});
      ge_sq = (sh >= trial);
      if (DO_SQ) begin
        stg_nxt.srem = ge_sq ? (ROOT_W+2)'(sh - trial) : sh[ROOT_W+1:0];
        stg_nxt.root = {st[k].root[ROOT_W-2:0], ge_sq};
      end
    end

    always_ff @(posedge clk) begin
      if (en) stg_r <= stg_nxt;
    end

    assign st[k+1] = stg_r;
  end

  // saturation and final select
  stage_t                  fin;
  logic signed [RES_W-1:0] qre_s, qim_s, res_re_nxt, res_im_nxt;

  always_comb begin
    fin   = st[DIV_STEPS];
    qre_s = RES_W'(fin.qre);
    qim_s = RES_W'(fin.qim);
    case (fin.kind)
      K_DIV: begin
        if (fin.neg_re) res_re_nxt = fin.ovf_re ? MIN_N : -qre_s;
        else            res_re_nxt = fin.ovf_re ? MAX_P : qre_s;
        if (fin.neg_im) res_im_nxt = fin.ovf_im ? MIN_N : -qim_s;
        else            res_im_nxt = fin.ovf_im ? MAX_P : qim_s;
      end
      K_MOD: begin
        res_re_nxt = RES_W'(fin.root);
        res_im_nxt = '0;
      end
      default: begin
        res_re_nxt = fin.dir_re;
        res_im_nxt = fin.dir_im;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ore_r <= res_re_nxt;
      oim_r <= res_im_nxt;
      odz_r <= fin.dz;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {(OUT_DATA_W-2*RES_W)'(0), oim_r, ore_r};
  assign out_tuser  = odz_r;

endmodule
`default_nettype wire

/* rtl/core/complex_arithmetic_unit.sv */
// Complex arithmetic unit: add, subtract, multiply, divide or modulus of two
// Q8.8 complex operands, one Q18.16 result per word. A word is accepted on
// every clock while the output is drained; when nothing stalls, a result
// passes the input register, the queue, two preparation stages, 33 stages
// of the pipelined divider, which also hosts the square root, and the output
// register. Divide results saturate; a zero divisor gives a zero result with
// div_zero set. Depends on cau_pkg and the cau_* modules.
`default_nettype none
module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // a_re, a_im, b_re, b_im
  input  wire logic [OP_W-1:0]       in_tuser,   // opcode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // res_re, res_im, zero pad
  output logic                       out_tuser   // div_zero
);

  logic    q_push, q_ready, q_valid, q_pop;
  qentry_t q_in, q_out;
  qstat_t  q_stat;

  cau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_data    (q_in),
    .q_ready   (q_ready)
  );

  cau_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_out),
    .pop        (q_pop),
    .stat       (q_stat)
  );

  cau_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // zero divisor must always come with an all-zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("div_zero word with nonzero result");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.cnt <= (QA_W+1)'(QDEPTH) && (q_stat.full == (q_stat.cnt == (QA_W+1)'(QDEPTH))))
    else $error("queue count out of range");

  a_q_flow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full && !q_pop |=> !q_stat.empty)
    else $error("queue lost entries");

endmodule
`default_nettype wire
